// ----- rtl/cpt_pkg.sv -----
// Shared types and widths for the closest-point-on-triangle pipeline.
// No dependencies; used by cpt_mul and closest_point_on_triangle.
`default_nettype none

package cpt_pkg;

	// coordinate format
	localparam int CPT_COORD_W   = 32;
	localparam int CPT_FRAC_BITS = 16;

	// limb width of the split multipliers
	localparam int CPT_LIMB_W = 32;

	// internal widths, all exact
	localparam int CPT_DIFF_W = CPT_COORD_W + 1;
	localparam int CPT_DOT_W  = 2 * CPT_DIFF_W + 2;
	localparam int CPT_VOL_W  = 2 * CPT_DOT_W + 1;
	localparam int CPT_DIV_W  = CPT_VOL_W + 2;

	typedef logic signed [CPT_COORD_W-1:0] coord_t;
	typedef logic signed [CPT_DIFF_W-1:0]  diff_t;
	typedef logic signed [CPT_DOT_W-1:0]   dot_t;
	typedef logic signed [CPT_VOL_W-1:0]   vol_t;

	typedef struct packed {
		coord_t query_x;
		coord_t query_y;
		coord_t query_z;
		coord_t vert_a_x;
		coord_t vert_a_y;
		coord_t vert_a_z;
		coord_t vert_b_x;
		coord_t vert_b_y;
		coord_t vert_b_z;
		coord_t vert_c_x;
		coord_t vert_c_y;
		coord_t vert_c_z;
	} req_t;

	typedef struct packed {
		coord_t     near_x;
		coord_t     near_y;
		coord_t     near_z;
		logic [2:0] region;
	} rsp_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct packed {
		diff_t x;
		diff_t y;
		diff_t z;
	} edge_t;

	typedef enum logic [2:0] {
		REG_A    = 3'd0,
		REG_B    = 3'd1,
		REG_C    = 3'd2,
		REG_AB   = 3'd3,
		REG_AC   = 3'd4,
		REG_BC   = 3'd5,
		REG_FACE = 3'd6
	} region_t;

endpackage

`default_nettype wire

// ----- rtl/cpt_mul.sv -----
// Two-stage signed multiplier built from limb partial products.
// Depends on cpt_pkg for the limb width.
`default_nettype none

module cpt_mul #(
	parameter int A_W = 33,
	parameter int B_W = 33
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic signed [A_W-1:0]  a,
	input  wire logic signed [B_W-1:0]  b,
	output logic signed [A_W+B_W-1:0]   p
);
	import cpt_pkg::*;

	localparam int NA    = (A_W + CPT_LIMB_W - 1) / CPT_LIMB_W;
	localparam int NB    = (B_W + CPT_LIMB_W - 1) / CPT_LIMB_W;
	localparam int AX_W  = NA * CPT_LIMB_W;
	localparam int BX_W  = NB * CPT_LIMB_W;
	localparam int PP_W  = 2 * CPT_LIMB_W + 2;
	localparam int SUM_W = AX_W + BX_W + 2;

	logic signed [AX_W-1:0]       ax;
	logic signed [BX_W-1:0]       bx;
	logic signed [CPT_LIMB_W:0]   la [NA];
	logic signed [CPT_LIMB_W:0]   lb [NB];
	logic signed [PP_W-1:0]       pp_s1 [NA][NB];
	logic signed [SUM_W-1:0]      acc;
	logic signed [A_W+B_W-1:0]    p_s2;

	assign ax = AX_W'(a);
	assign bx = BX_W'(b);

	// lower limbs unsigned, top limb carries the sign
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			if (i == NA - 1)
				la[i] = $signed({ax[AX_W-1], ax[i*CPT_LIMB_W +: CPT_LIMB_W]});
			else
				la[i] = $signed({1'b0, ax[i*CPT_LIMB_W +: CPT_LIMB_W]});
		end
		for (int j = 0; j < NB; j++) begin
			if (j == NB - 1)
				lb[j] = $signed({bx[BX_W-1], bx[j*CPT_LIMB_W +: CPT_LIMB_W]});
			else
				lb[j] = $signed({1'b0, bx[j*CPT_LIMB_W +: CPT_LIMB_W]});
		end
	end

	// stage 1: partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++)
				for (int j = 0; j < NB; j++)
					pp_s1[i][j] <= la[i] * lb[j];
		end
	end

	// stage 2: weighted sum of the partial products
	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++)
			for (int j = 0; j < NB; j++)
				acc = acc + (SUM_W'(pp_s1[i][j]) <<< (CPT_LIMB_W * (i + j)));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= acc[A_W+B_W-1:0];
		end
	end

	assign p = p_s2;

endmodule

`default_nettype wire

// ----- rtl/cpt_div.sv -----
// Pipelined restoring divider for barycentric weights, one quotient bit a stage.
// Needs 0 <= num <= den; a zero divisor gives zero. No package dependency.
`default_nettype none

module cpt_div #(
	parameter int OP_W      = 139,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [OP_W-1:0]      num,
	input  wire logic [OP_W-1:0]      den,
	output logic      [FRAC_BITS:0]   q
);

	localparam int NS = FRAC_BITS + 1;
	localparam int RW = OP_W + 1;

	logic [RW-1:0]   rem_sk  [NS];
	logic [OP_W-1:0] den_sk  [NS];
	logic [NS-1:0]   quo_sk  [NS];
	logic            zero_sk [NS];

	for (genvar k = 0; k < NS; k++) begin : g_step
		logic [RW-1:0]   r_in;
		logic [RW-1:0]   r_sub;
		logic [OP_W-1:0] d_in;
		logic [NS-1:0]   q_in;
		logic            z_in;
		logic            ge;

		if (k == 0) begin : g_first
			assign r_in = {1'b0, num};
			assign d_in = den;
			assign q_in = '0;
			assign z_in = (den == '0);
		end else begin : g_next
			assign r_in = rem_sk[k-1];
			assign d_in = den_sk[k-1];
			assign q_in = quo_sk[k-1];
			assign z_in = zero_sk[k-1];
		end

		// compare and subtract, remainder doubled for the next bit
		assign ge    = (r_in >= {1'b0, d_in});
		assign r_sub = ge ? (r_in - {1'b0, d_in}) : r_in;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[k]  <= {r_sub[RW-2:0], 1'b0};
				den_sk[k]  <= d_in;
				quo_sk[k]  <= NS'({q_in, ge});
				zero_sk[k] <= z_in;
			end
		end
	end

	assign q = zero_sk[NS-1] ? '0 : quo_sk[NS-1];

endmodule

`default_nettype wire

// ----- rtl/closest_point_on_triangle.sv -----
// Closest point on a triangle to a query point, fixed point, fully pipelined.
// Depends on cpt_pkg, cpt_mul and cpt_div.
//
//   port group   dir   contents
//   req          in    query point and vertices a, b, c (req_t)
//   rsp          out   nearest point and region code (rsp_t)
//
// One word enters per cycle unless rsp stalls; the pipeline depth is set by
// the two split multiplier stages and one divider stage per quotient bit,
// the integer bit included.
// Reset clears only the valid bits; the pipeline is empty after it.
// A stall on rsp while a word waits freezes every stage, and req_stall follows.
`default_nettype none

module closest_point_on_triangle #(
	parameter int FRAC_BITS = cpt_pkg::CPT_FRAC_BITS
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire cpt_pkg::req_t   req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output cpt_pkg::rsp_t        rsp
);
	import cpt_pkg::*;

	localparam int NS   = FRAC_BITS + 1;
	localparam int W    = CPT_COORD_W;
	localparam int EW   = CPT_DOT_W + 1;
	localparam int TW   = CPT_DIFF_W + FRAC_BITS + 2;
	localparam int SUMW = W + 3;

	typedef struct packed {
		point_t a;
		point_t b;
		point_t c;
		edge_t  ab;
		edge_t  ac;
		edge_t  bc;
	} geo_t;

	typedef struct packed {
		point_t  base;
		edge_t   e1;
		edge_t   e2;
		region_t rgn;
	} tail_t;

	function automatic diff_t ecomp(edge_t e, int k);
		diff_t r;
		case (k)
			0:       r = e.x;
			1:       r = e.y;
			default: r = e.z;
		endcase
		return r;
	endfunction

	function automatic coord_t pcomp(point_t p, int k);
		coord_t r;
		case (k)
			0:       r = p.x;
			1:       r = p.y;
			default: r = p.z;
		endcase
		return r;
	endfunction

	logic en;

	// valid chain
	logic          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic [NS-1:0] vld_sd;
	logic          vld_s9, vld_s10;

	// payload
	geo_t  geo_s1, geo_s2, geo_s3, geo_s4, geo_s5, geo_s6, geo_s7;
	edge_t ap_s1, bp_s1, cp_s1;
	dot_t  dot_s4 [6];
	dot_t  dot_s5 [6];
	dot_t  dot_s6 [6];
	dot_t  dot_s7 [6];
	vol_t  vc_s7, vb_s7, va_s7;

	edge_t lhs [6];
	edge_t rhs [6];
	logic signed [2*CPT_DIFF_W-1:0] dprod [6][3];
	dot_t  ml [6];
	dot_t  mr [6];
	logic signed [2*CPT_DOT_W-1:0]  vprod [6];

	dot_t d1, d2, d3, d4, d5, d6;
	logic signed [EW-1:0]   den_ab, den_ac, num_bc;
	logic signed [EW:0]     den_bc;
	logic signed [CPT_DIV_W-1:0] den_face;
	logic [CPT_DIV_W-1:0]   num0_c, den0_c, num1_c, den1_c;
	logic [CPT_DIV_W-1:0]   num0_s8, den0_s8, num1_s8, den1_s8;
	tail_t tail_c, tail_s8;
	tail_t tail_sd [NS];
	logic [FRAC_BITS:0] w0, w1;

	logic signed [TW-1:0] t1_s9 [3];
	logic signed [TW-1:0] t2_s9 [3];
	point_t  base_s9;
	region_t rgn_s9;
	logic signed [SUMW-1:0] sum_c [3];
	coord_t  near_c [3];
	rsp_t    rsp_s10;

	// whole pipeline moves unless a finished word is held
	assign en        = !(vld_s10 && rsp_stall);
	assign req_stall = !en;
	assign rsp_valid = vld_s10;
	assign rsp       = rsp_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_sd  <= '0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s1  <= req_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_sd  <= NS'({vld_sd, vld_s8});
			vld_s9  <= vld_sd[NS-1];
			vld_s10 <= vld_s9;
		end
	end

	// stage 1: edge and offset vectors
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s1.a  <= '{req.vert_a_x, req.vert_a_y, req.vert_a_z};
			geo_s1.b  <= '{req.vert_b_x, req.vert_b_y, req.vert_b_z};
			geo_s1.c  <= '{req.vert_c_x, req.vert_c_y, req.vert_c_z};
			geo_s1.ab <= '{CPT_DIFF_W'(req.vert_b_x) - CPT_DIFF_W'(req.vert_a_x),
			               CPT_DIFF_W'(req.vert_b_y) - CPT_DIFF_W'(req.vert_a_y),
			               CPT_DIFF_W'(req.vert_b_z) - CPT_DIFF_W'(req.vert_a_z)};
			geo_s1.ac <= '{CPT_DIFF_W'(req.vert_c_x) - CPT_DIFF_W'(req.vert_a_x),
			               CPT_DIFF_W'(req.vert_c_y) - CPT_DIFF_W'(req.vert_a_y),
			               CPT_DIFF_W'(req.vert_c_z) - CPT_DIFF_W'(req.vert_a_z)};
			geo_s1.bc <= '{CPT_DIFF_W'(req.vert_c_x) - CPT_DIFF_W'(req.vert_b_x),
			               CPT_DIFF_W'(req.vert_c_y) - CPT_DIFF_W'(req.vert_b_y),
			               CPT_DIFF_W'(req.vert_c_z) - CPT_DIFF_W'(req.vert_b_z)};
			ap_s1 <= '{CPT_DIFF_W'(req.query_x) - CPT_DIFF_W'(req.vert_a_x),
			           CPT_DIFF_W'(req.query_y) - CPT_DIFF_W'(req.vert_a_y),
			           CPT_DIFF_W'(req.query_z) - CPT_DIFF_W'(req.vert_a_z)};
			bp_s1 <= '{CPT_DIFF_W'(req.query_x) - CPT_DIFF_W'(req.vert_b_x),
			           CPT_DIFF_W'(req.query_y) - CPT_DIFF_W'(req.vert_b_y),
			           CPT_DIFF_W'(req.query_z) - CPT_DIFF_W'(req.vert_b_z)};
			cp_s1 <= '{CPT_DIFF_W'(req.query_x) - CPT_DIFF_W'(req.vert_c_x),
			           CPT_DIFF_W'(req.query_y) - CPT_DIFF_W'(req.vert_c_y),
			           CPT_DIFF_W'(req.query_z) - CPT_DIFF_W'(req.vert_c_z)};
		end
	end

	// dot product operands: d1..d6
	assign lhs[0] = geo_s1.ab;  assign rhs[0] = ap_s1;
	assign lhs[1] = geo_s1.ac;  assign rhs[1] = ap_s1;
	assign lhs[2] = geo_s1.ab;  assign rhs[2] = bp_s1;
	assign lhs[3] = geo_s1.ac;  assign rhs[3] = bp_s1;
	assign lhs[4] = geo_s1.ab;  assign rhs[4] = cp_s1;
	assign lhs[5] = geo_s1.ac;  assign rhs[5] = cp_s1;

	// stages 2-3: component products
	for (genvar i = 0; i < 6; i++) begin : g_dot
		for (genvar k = 0; k < 3; k++) begin : g_comp
			cpt_mul #(
				.A_W (CPT_DIFF_W),
				.B_W (CPT_DIFF_W)
			) u_mul (
				.clk (clk),
				.en  (en),
				.a   (ecomp(lhs[i], k)),
				.b   (ecomp(rhs[i], k)),
				.p   (dprod[i][k])
			);
		end
	end

	// geometry follows the dot products
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s2 <= geo_s1;
			geo_s3 <= geo_s2;
			geo_s4 <= geo_s3;
			geo_s5 <= geo_s4;
			geo_s6 <= geo_s5;
			geo_s7 <= geo_s6;
		end
	end

	// stage 4: dot sums, then carried alongside the second products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++) begin
				dot_s4[i] <= CPT_DOT_W'(dprod[i][0]) + CPT_DOT_W'(dprod[i][1])
				           + CPT_DOT_W'(dprod[i][2]);
				dot_s5[i] <= dot_s4[i];
				dot_s6[i] <= dot_s5[i];
				dot_s7[i] <= dot_s6[i];
			end
		end
	end

	// vc = d1*d4 - d3*d2, vb = d5*d2 - d1*d6, va = d3*d6 - d5*d4
	assign ml[0] = dot_s4[0];  assign mr[0] = dot_s4[3];
	assign ml[1] = dot_s4[2];  assign mr[1] = dot_s4[1];
	assign ml[2] = dot_s4[4];  assign mr[2] = dot_s4[1];
	assign ml[3] = dot_s4[0];  assign mr[3] = dot_s4[5];
	assign ml[4] = dot_s4[2];  assign mr[4] = dot_s4[5];
	assign ml[5] = dot_s4[4];  assign mr[5] = dot_s4[3];

	// stages 5-6: cross products of dots
	for (genvar i = 0; i < 6; i++) begin : g_vol
		cpt_mul #(
			.A_W (CPT_DOT_W),
			.B_W (CPT_DOT_W)
		) u_mul (
			.clk (clk),
			.en  (en),
			.a   (ml[i]),
			.b   (mr[i]),
			.p   (vprod[i])
		);
	end

	// stage 7: barycentric volumes
	always_ff @(posedge clk) begin
		if (en) begin
			vc_s7 <= CPT_VOL_W'(vprod[0]) - CPT_VOL_W'(vprod[1]);
			vb_s7 <= CPT_VOL_W'(vprod[2]) - CPT_VOL_W'(vprod[3]);
			va_s7 <= CPT_VOL_W'(vprod[4]) - CPT_VOL_W'(vprod[5]);
		end
	end

	// stage 8: region test and weight operands
	assign d1 = dot_s7[0];
	assign d2 = dot_s7[1];
	assign d3 = dot_s7[2];
	assign d4 = dot_s7[3];
	assign d5 = dot_s7[4];
	assign d6 = dot_s7[5];

	assign den_ab   = EW'(d1) - EW'(d3);
	assign den_ac   = EW'(d2) - EW'(d6);
	assign num_bc   = EW'(d4) - EW'(d3);
	assign den_bc   = (EW+1)'(num_bc) + (EW+1)'(EW'(d5) - EW'(d6));
	assign den_face = CPT_DIV_W'(va_s7) + CPT_DIV_W'(vb_s7) + CPT_DIV_W'(vc_s7);

	always_comb begin
		tail_c.base = geo_s7.a;
		tail_c.e1   = geo_s7.ab;
		tail_c.e2   = geo_s7.ac;
		tail_c.rgn  = REG_FACE;
		num0_c      = '0;
		den0_c      = '0;
		num1_c      = '0;
		den1_c      = '0;
		if (d1 <= 0 && d2 <= 0) begin
			tail_c.rgn = REG_A;
		end else if (d3 >= 0 && d4 <= d3) begin
			tail_c.rgn  = REG_B;
			tail_c.base = geo_s7.b;
		end else if (d6 >= 0 && d5 <= d6) begin
			tail_c.rgn  = REG_C;
			tail_c.base = geo_s7.c;
		end else if (vc_s7 <= 0 && d1 >= 0 && d3 <= 0) begin
			tail_c.rgn = REG_AB;
			num0_c     = CPT_DIV_W'(d1);
			den0_c     = CPT_DIV_W'(den_ab);
		end else if (vb_s7 <= 0 && d2 >= 0 && d6 <= 0) begin
			tail_c.rgn = REG_AC;
			tail_c.e1  = geo_s7.ac;
			num0_c     = CPT_DIV_W'(d2);
			den0_c     = CPT_DIV_W'(den_ac);
		end else if (va_s7 <= 0 && num_bc >= 0 && (EW'(d5) - EW'(d6)) >= 0) begin
			tail_c.rgn  = REG_BC;
			tail_c.base = geo_s7.b;
			tail_c.e1   = geo_s7.bc;
			num0_c      = CPT_DIV_W'(num_bc);
			den0_c      = CPT_DIV_W'(den_bc);
		end else if (den_face == '0) begin
			// degenerate face falls back to vertex a
			tail_c.rgn = REG_A;
		end else begin
			num0_c = CPT_DIV_W'(vb_s7);
			den0_c = den_face;
			num1_c = CPT_DIV_W'(vc_s7);
			den1_c = den_face;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tail_s8 <= tail_c;
			num0_s8 <= num0_c;
			den0_s8 <= den0_c;
			num1_s8 <= num1_c;
			den1_s8 <= den1_c;
		end
	end

	// weights, one bit a stage
	cpt_div #(
		.OP_W      (CPT_DIV_W),
		.FRAC_BITS (FRAC_BITS)
	) u_div0 (
		.clk (clk),
		.en  (en),
		.num (num0_s8),
		.den (den0_s8),
		.q   (w0)
	);

	cpt_div #(
		.OP_W      (CPT_DIV_W),
		.FRAC_BITS (FRAC_BITS)
	) u_div1 (
		.clk (clk),
		.en  (en),
		.num (num1_s8),
		.den (den1_s8),
		.q   (w1)
	);

	// placement data rides alongside the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			tail_sd[0] <= tail_s8;
			for (int k = 1; k < NS; k++)
				tail_sd[k] <= tail_sd[k-1];
		end
	end

	// stage after the dividers: weighted edge terms
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				t1_s9[k] <= ecomp(tail_sd[NS-1].e1, k) * $signed({1'b0, w0});
				t2_s9[k] <= ecomp(tail_sd[NS-1].e2, k) * $signed({1'b0, w1});
			end
			base_s9 <= tail_sd[NS-1].base;
			rgn_s9  <= tail_sd[NS-1].rgn;
		end
	end

	// final stage: add to base and saturate
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum_c[k] = SUMW'(pcomp(base_s9, k)) + SUMW'(t1_s9[k] >>> FRAC_BITS)
			         + SUMW'(t2_s9[k] >>> FRAC_BITS);
			if (sum_c[k][SUMW-1:W-1] == '0 || sum_c[k][SUMW-1:W-1] == '1)
				near_c[k] = sum_c[k][W-1:0];
			else if (sum_c[k][SUMW-1])
				near_c[k] = {1'b1, {(W-1){1'b0}}};
			else
				near_c[k] = {1'b0, {(W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_s10.near_x <= near_c[0];
			rsp_s10.near_y <= near_c[1];
			rsp_s10.near_z <= near_c[2];
			rsp_s10.region <= rgn_s9;
		end
	end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking bench for closest_point_on_triangle: wide-integer predictor, random traffic.
// Depends on cpt_pkg and the block under test.
`default_nettype none

module tb;
	import cpt_pkg::*;

	localparam int FRAC  = CPT_FRAC_BITS;
	localparam int NRAND = 1730;
	localparam int LIMIT = 400000;
	localparam int DRAIN = 40;

	typedef logic signed [255:0] wide_t;

	// expected nearest points, oldest first, with the checks against them
	class near_point_board;
		rsp_t expected[$];
		int   mismatches;
		int   checked;
		int   region_seen[7];

		function wide_t dot3(wide_t u[3], wide_t v[3]);
			return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
		endfunction

		function wide_t ratio(wide_t num, wide_t den);
			if (den == 0)
				return 0;
			return (num <<< FRAC) / den;
		endfunction

		function coord_t blend(wide_t base, wide_t e1, wide_t t1, wide_t e2, wide_t t2);
			wide_t s;
			wide_t hi;
			wide_t lo;
			hi = (wide_t'(1) <<< (CPT_COORD_W - 1)) - 1;
			lo = -hi - 1;
			s = base + ((e1 * t1) >>> FRAC) + ((e2 * t2) >>> FRAC);
			if (s > hi)
				s = hi;
			else if (s < lo)
				s = lo;
			return coord_t'(s);
		endfunction

		// predict the word the block should return for this query
		function void note(req_t r);
			wide_t p[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
			wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, e1, e2, den, z;
			wide_t base[3], ea[3], eb[3];
			wide_t ta, tb_w;
			region_t rgn;
			rsp_t w;
			p = '{r.query_x, r.query_y, r.query_z};
			a = '{r.vert_a_x, r.vert_a_y, r.vert_a_z};
			b = '{r.vert_b_x, r.vert_b_y, r.vert_b_z};
			c = '{r.vert_c_x, r.vert_c_y, r.vert_c_z};
			for (int k = 0; k < 3; k++) begin
				ab[k] = b[k] - a[k]; ac[k] = c[k] - a[k]; bc[k] = c[k] - b[k];
				ap[k] = p[k] - a[k]; bp[k] = p[k] - b[k]; cp[k] = p[k] - c[k];
			end
			z  = 0;
			d1 = dot3(ab, ap); d2 = dot3(ac, ap);
			d3 = dot3(ab, bp); d4 = dot3(ac, bp);
			d5 = dot3(ab, cp); d6 = dot3(ac, cp);
			vc = d1 * d4 - d3 * d2;
			vb = d5 * d2 - d1 * d6;
			va = d3 * d6 - d5 * d4;
			e1 = d4 - d3; e2 = d5 - d6;
			base = a; ea = ab; eb = ac; ta = z; tb_w = z;
			if (d1 <= 0 && d2 <= 0) begin
				rgn = REG_A;
			end else if (d3 >= 0 && d4 <= d3) begin
				rgn = REG_B; base = b;
			end else if (d6 >= 0 && d5 <= d6) begin
				rgn = REG_C; base = c;
			end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
				rgn = REG_AB; ta = ratio(d1, d1 - d3);
			end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
				rgn = REG_AC; ea = ac; ta = ratio(d2, d2 - d6);
			end else if (va <= 0 && e1 >= 0 && e2 >= 0) begin
				rgn = REG_BC; base = b; ea = bc; ta = ratio(e1, e1 + e2);
			end else begin
				den = va + vb + vc;
				if (den == 0) begin
					rgn = REG_A;
				end else begin
					rgn = REG_FACE; ta = ratio(vb, den); tb_w = ratio(vc, den);
				end
			end
			w.near_x = blend(base[0], ea[0], ta, eb[0], tb_w);
			w.near_y = blend(base[1], ea[1], ta, eb[1], tb_w);
			w.near_z = blend(base[2], ea[2], ta, eb[2], tb_w);
			w.region = rgn;
			region_seen[rgn]++;
			expected.push_back(w);
		endfunction

		function void check(rsp_t got);
			rsp_t want;
			checked++;
			if (expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: %p", got);
				return;
			end
			want = expected.pop_front();
			if (got.near_x !== want.near_x || got.near_y !== want.near_y ||
					got.near_z !== want.near_z || got.region !== want.region) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch word %0d: want %0d %0d %0d r%0d got %0d %0d %0d r%0d",
						checked, want.near_x, want.near_y, want.near_z, want.region,
						got.near_x, got.near_y, got.near_z, got.region);
			end
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic   clk;
	logic   arst_n;
	logic   req_valid;
	logic   req_stall;
	req_t   req;
	logic   rsp_valid;
	logic   rsp_stall;
	rsp_t   rsp;

	near_point_board board;
	req_t   queries[$];
	int     cycles = 0;
	bit     quiet;
	bit     hold_ask;

	closest_point_on_triangle dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// accepted words on both sides
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall)
			board.note(req);
		if (arst_n && rsp_valid && !rsp_stall)
			board.check(rsp);
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin : receiver
		int left;
		bit stall_now;
		left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_ask) begin
				rsp_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_ask = 0;
				left = 0;
				rsp_stall <= 1'b0;
			end else if (quiet) begin
				rsp_stall <= 1'b0;
			end else if (left > 0) begin
				left--;
			end else begin
				stall_now = ($urandom_range(0, 2) == 0);
				left = $urandom_range(1, 8) - 1;
				rsp_stall <= stall_now;
			end
		end
	end

	// integer units to Q16.16
	function automatic coord_t q(int v);
		return coord_t'(v <<< FRAC);
	endfunction

	function automatic req_t tri_q(int px, int py, int pz, int ax, int ay, int az,
			int bx, int by, int bz, int cx, int cy, int cz);
		return '{q(px), q(py), q(pz), q(ax), q(ay), q(az),
			q(bx), q(by), q(bz), q(cx), q(cy), q(cz)};
	endfunction

	function automatic coord_t rnd_coord(int scale_shift);
		return coord_t'($signed($urandom) >>> scale_shift);
	endfunction

	task automatic build_stimulus();
		req_t r;
		coord_t mx, mn;
		int kind, sh;
		mx = {1'b0, {(CPT_COORD_W-1){1'b1}}};
		mn = {1'b1, {(CPT_COORD_W-1){1'b0}}};
		// each region of a plain right triangle
		queries.push_back(tri_q(-1, -1, 0, 0, 0, 0, 4, 0, 0, 0, 4, 0));
		queries.push_back(tri_q(5, -1, 0, 0, 0, 0, 4, 0, 0, 0, 4, 0));
		queries.push_back(tri_q(-1, 5, 0, 0, 0, 0, 4, 0, 0, 0, 4, 0));
		queries.push_back(tri_q(2, -1, 3, 0, 0, 0, 4, 0, 0, 0, 4, 0));
		queries.push_back(tri_q(-1, 2, 0, 0, 0, 0, 4, 0, 0, 0, 4, 0));
		queries.push_back(tri_q(3, 3, 1, 0, 0, 0, 4, 0, 0, 0, 4, 0));
		queries.push_back(tri_q(1, 1, 5, 0, 0, 0, 4, 0, 0, 0, 4, 0));
		queries.push_back(tri_q(1, 1, -2, 0, 0, 0, 3, 0, 0, 0, 7, 0));
		// collapsed triangles: a point, a line, coincident edge ends
		queries.push_back(tri_q(3, 2, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1));
		queries.push_back(tri_q(1, 5, 0, 0, 0, 0, 2, 0, 0, 4, 0, 0));
		queries.push_back(tri_q(1, -3, 0, 0, 0, 0, 0, 0, 0, 0, 4, 0));
		queries.push_back(tri_q(2, 2, 2, 1, 0, 0, 1, 0, 0, 1, 0, 0));
		// query on a vertex
		queries.push_back(tri_q(4, 0, 0, 0, 0, 0, 4, 0, 0, 0, 4, 0));
		// field extremes and saturation
		queries.push_back({12{mx}});
		queries.push_back({12{mn}});
		queries.push_back('{mx, mx, mx, mn, mn, mn, mx, mn, mn, mn, mx, mn});
		queries.push_back('{mn, mx, mn, mx, mn, mx, mn, mx, mx, mx, mx, mn});
		queries.push_back('{mx, mn, 0, mn, mn, 0, mx, mx, 0, mn, mx, 0});
		queries.push_back('{0, 0, mx, mn, mn, mn, mx, mn, mn, mn, mx, mn});
		queries.push_back('{mn, mn, mn, mx, mx, mx, mn, mx, mx, mx, mn, mx});
		// random part: mostly sized triangles, some full range and collapsed shapes
		for (int i = 0; i < NRAND; i++) begin
			kind = $urandom_range(0, 9);
			sh = (kind == 0) ? 0 : $urandom_range(1, 26);
			for (int f = 0; f < 12; f++)
				r[CPT_COORD_W*f +: CPT_COORD_W] = rnd_coord(sh);
			case (kind)
				1: begin r.vert_b_x = r.vert_a_x; r.vert_b_y = r.vert_a_y; r.vert_b_z = r.vert_a_z; end
				2: begin r.vert_c_x = r.vert_a_x; r.vert_c_y = r.vert_a_y; r.vert_c_z = r.vert_a_z; end
				3: begin r.vert_c_x = r.vert_b_x; r.vert_c_y = r.vert_b_y; r.vert_c_z = r.vert_b_z; end
				4: begin r.query_x = r.vert_b_x; r.query_y = r.vert_b_y; r.query_z = r.vert_b_z; end
				5: begin r.query_z = r.vert_a_z; r.vert_b_z = r.vert_a_z; r.vert_c_z = r.vert_a_z; end
				default: ;
			endcase
			queries.push_back(r);
		end
	endtask

	// sender: offers each query, with idle bursts, one pause to drain
	task automatic send_all();
		int n, idle;
		n = queries.size();
		for (int i = 0; i < n; i++) begin
			if (i == n - 200)
				quiet = 1;
			if (i == 600)
				hold_ask = 1;
			if (i == 1000) begin
				req_valid <= 1'b0;
				while (board.pending() != 0) @(posedge clk);
			end
			if (!quiet && $urandom_range(0, 3) == 0) begin
				idle = $urandom_range(1, 8);
				req_valid <= 1'b0;
				repeat (idle) @(posedge clk);
			end
			req_valid <= 1'b1;
			req <= queries[i];
			@(posedge clk);
			while (req_stall) @(posedge clk);
		end
		req_valid <= 1'b0;
	endtask

	initial begin
		board = new();
		req_valid = 1'b0;
		rsp_stall = 1'b0;
		req = '0;
		arst_n = 1'b0;
		quiet = 0;
		hold_ask = 0;
		build_stimulus();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_all();
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("%0d queries checked; regions a/b/c/ab/ac/bc/face: %0d %0d %0d %0d %0d %0d %0d",
			board.checked, board.region_seen[0], board.region_seen[1], board.region_seen[2],
			board.region_seen[3], board.region_seen[4], board.region_seen[5],
			board.region_seen[6]);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("[ OK ] regression clean");
		else begin
			$display("%0d mismatches, %0d outstanding", board.mismatches, board.pending());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/cpt_pkg.sv
rtl/cpt_mul.sv
rtl/cpt_div.sv
rtl/closest_point_on_triangle.sv
tb/tb.sv
